// File: rtl/bpsd_pkg.sv
// bpsd_pkg: types, sizes and state codes for the subset-DP bin packer
// no dependencies; used by bin_packing_subset_dp and bpsd_engine
`timescale 1ns / 1ps
`default_nettype none

package bpsd_pkg;

  localparam int MAX_ITEMS   = 16;
  localparam int WEIGHT_BITS = 32;
  localparam int IDX_W       = $clog2(MAX_ITEMS);
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
  localparam int MASK_W      = MAX_ITEMS;
  localparam int NUM_SUBSETS = 1 << MAX_ITEMS;
  localparam int ENTRY_W     = CNT_W + WEIGHT_BITS;

  // output field widths fixed by the result word
  localparam int ITEM_NUM_W  = 5;
  localparam int BIN_IDX_W   = 4;
  localparam int BIN_CNT_W   = 5;

  // best pair of one subset
  typedef struct packed {
    logic [CNT_W-1:0]       closed;
    logic [WEIGHT_BITS-1:0] load;
  } subset_best_t;

  // request towards the subset memory
  typedef struct packed {
    logic                   we;
    logic [MASK_W-1:0]      waddr;
    subset_best_t           wdata;
    logic [MASK_W-1:0]      raddr;
  } ram_req_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DP_RD,
    ST_DP_EV,
    ST_DP_WR,
    ST_WB_RD0,
    ST_WB_LD0,
    ST_WB_RD,
    ST_WB_EV,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

// File: rtl/bpsd_ifs.sv
// bpsd_ifs: valid/ready channels for item, result and capacity words
// depends on bpsd_pkg for nothing but is compiled after it
`timescale 1ns / 1ps
`default_nettype none

interface bpsd_item_if;
  logic        valid;
  logic        ready;
  logic [31:0] item_weight;
  logic        last_item;
  modport source (output valid, item_weight, last_item, input ready);
  modport sink   (input valid, item_weight, last_item, output ready);
endinterface

interface bpsd_result_if;
  logic       valid;
  logic       ready;
  logic [4:0] item_number;
  logic [3:0] bin_index;
  logic [4:0] bin_count;
  logic       input_error;
  logic       last_result;
  modport source (output valid, item_number, bin_index, bin_count, input_error,
                  last_result, input ready);
  modport sink   (input valid, item_number, bin_index, bin_count, input_error,
                  last_result, output ready);
endinterface

interface bpsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] bin_capacity;
  modport source (output valid, bin_capacity, input ready);
  modport sink   (input valid, bin_capacity, output ready);
endinterface

`default_nettype wire

// File: rtl/bin_packing_subset_dp.sv
// Subset-DP bin packer; takes one item word per cycle while loading.
// A run of n items goes through the DP pass over each non-empty subset (a read
// and an evaluate per item of each subset, then one subset write), then fetches
// the full set and gives each result word of the walk-back after reads and evaluates up to a match.
// An error run gives one word; the next set is taken once the last word leaves.
// Reset clears control, capacity to all ones; subset memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module bin_packing_subset_dp (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  bpsd_item_if.sink     item_i,
  bpsd_result_if.source result_o,
  bpsd_cfg_if.sink      cfg_i
);

  logic [bpsd_pkg::WEIGHT_BITS-1:0] cap_q;
  bpsd_pkg::ram_req_t               ram_req;
  bpsd_pkg::subset_best_t           ram_rdata;

  // capacity register, always writable
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '1;
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.bin_capacity;
    end
  end

  // subset memory
  bpsd_ram #(
    .WIDTH (bpsd_pkg::ENTRY_W),
    .DEPTH (bpsd_pkg::NUM_SUBSETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer
  bpsd_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bin_capacity_i (cap_q),
    .item_i         (item_i),
    .result_o       (result_o),
    .ram_req_o      (ram_req),
    .ram_rdata_i    (ram_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/bpsd_ram.sv
// bpsd_ram: generic single-write, single-read RAM with registered read
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module bpsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/bpsd_engine.sv
// bpsd_engine: weight loading, subset DP sequencer and walk-back
// depends on bpsd_pkg and bpsd_ifs; drives the subset memory
`timescale 1ns / 1ps
`default_nettype none

module bpsd_engine (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [bpsd_pkg::WEIGHT_BITS-1:0] bin_capacity_i,
  bpsd_item_if.sink                           item_i,
  bpsd_result_if.source                       result_o,
  output      bpsd_pkg::ram_req_t             ram_req_o,
  input  wire bpsd_pkg::subset_best_t         ram_rdata_i
);

  localparam int MW = bpsd_pkg::MASK_W;
  localparam int WB = bpsd_pkg::WEIGHT_BITS;
  localparam int CW = bpsd_pkg::CNT_W;
  localparam int IW = bpsd_pkg::IDX_W;

  bpsd_pkg::state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] n_q, n_d;
  logic          err_q, err_d;
  logic [WB-1:0] weights_q [bpsd_pkg::MAX_ITEMS];
  logic          wr_weight;

  logic [MW-1:0] mask_q, mask_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          have_q, have_d;
  bpsd_pkg::subset_best_t best_q, best_d;
  logic [MW-1:0] cur_q, cur_d;
  bpsd_pkg::subset_best_t cur_best_q, cur_best_d;
  logic [bpsd_pkg::BIN_IDX_W-1:0] level_q, level_d;
  logic [bpsd_pkg::BIN_CNT_W-1:0] count_q, count_d;

  logic [bpsd_pkg::ITEM_NUM_W-1:0] o_item_q, o_item_d;
  logic [bpsd_pkg::BIN_IDX_W-1:0]  o_bin_q, o_bin_d;
  logic [bpsd_pkg::BIN_CNT_W-1:0]  o_cnt_q, o_cnt_d;
  logic                            o_err_q, o_err_d, o_last_q, o_last_d;

  // shared decode
  logic [MW:0]   full_ext;
  logic [MW-1:0] full_mask, bit_mask, pred, prev;
  logic [WB-1:0] w;
  logic          idx_last, accept, bad_w, trigger, err_new;
  bpsd_pkg::subset_best_t pb;
  logic          fit, less, m_fit, m_new, pred_zero;
  logic [WB:0]   room, sum;
  bpsd_pkg::subset_best_t cand;

  assign full_ext  = ({{MW{1'b0}}, 1'b1} << n_q) - {{MW{1'b0}}, 1'b1};
  assign full_mask = full_ext[MW-1:0];
  assign bit_mask  = {{(MW-1){1'b0}}, 1'b1} << idx_q;
  assign pred      = mask_q & ~bit_mask;
  assign prev      = cur_q & ~bit_mask;
  assign w         = weights_q[idx_q];
  assign idx_last  = ({1'b0, idx_q} == (n_q - CW'(1)));
  assign accept    = item_i.valid && item_i.ready;
  assign bad_w     = (item_i.item_weight == '0) || (item_i.item_weight > bin_capacity_i);
  assign err_new   = err_q || bad_w;
  assign trigger   = item_i.last_item || (cnt_q + CW'(1) == CW'(bpsd_pkg::MAX_ITEMS));
  assign wr_weight = accept && (cnt_q < CW'(bpsd_pkg::MAX_ITEMS));

  // predecessor pair; the empty set is the constant zero pair
  assign pred_zero = (state_q == bpsd_pkg::ST_WB_EV) ? (prev == '0) : (pred == '0);
  assign pb        = pred_zero ? '0 : ram_rdata_i;

  // transition of the predecessor by the current item
  assign room = {1'b0, bin_capacity_i} - {1'b0, pb.load};
  assign sum  = {1'b0, pb.load} + {1'b0, w};
  assign fit  = (pb.load <= bin_capacity_i) && ({1'b0, w} <= room);
  always_comb begin
    if (fit) begin
      cand.closed = pb.closed;
      cand.load   = sum[WB-1:0];
    end else begin
      cand.closed = pb.closed + CW'(1);
      cand.load   = w;
    end
  end
  assign less = (cand.closed < best_q.closed) ||
                ((cand.closed == best_q.closed) && (cand.load < best_q.load));

  // walk-back match against the current subset
  assign m_fit = (pb.closed == cur_best_q.closed) && (cur_best_q.load >= w) &&
                 ((cur_best_q.load - w) == pb.load);
  assign m_new = (pb.closed != cur_best_q.closed) &&
                 (pb.closed + CW'(1) == cur_best_q.closed) && (cur_best_q.load == w);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpsd_pkg::ST_LOAD: begin
        if (accept && trigger) begin
          state_d = err_new ? bpsd_pkg::ST_OUT : bpsd_pkg::ST_DP_RD;
        end
      end
      bpsd_pkg::ST_DP_RD: state_d = bpsd_pkg::ST_DP_EV;
      bpsd_pkg::ST_DP_EV: state_d = idx_last ? bpsd_pkg::ST_DP_WR : bpsd_pkg::ST_DP_RD;
      bpsd_pkg::ST_DP_WR: begin
        state_d = (mask_q == full_mask) ? bpsd_pkg::ST_WB_RD0 : bpsd_pkg::ST_DP_RD;
      end
      bpsd_pkg::ST_WB_RD0: state_d = bpsd_pkg::ST_WB_LD0;
      bpsd_pkg::ST_WB_LD0: state_d = bpsd_pkg::ST_WB_RD;
      bpsd_pkg::ST_WB_RD:  state_d = bpsd_pkg::ST_WB_EV;
      bpsd_pkg::ST_WB_EV: begin
        if (cur_q[idx_q] && (m_fit || m_new)) begin
          state_d = bpsd_pkg::ST_OUT;
        end else if (idx_last) begin
          state_d = bpsd_pkg::ST_LOAD;
        end else begin
          state_d = bpsd_pkg::ST_WB_RD;
        end
      end
      bpsd_pkg::ST_OUT: begin
        if (result_o.ready) begin
          state_d = o_last_q ? bpsd_pkg::ST_LOAD : bpsd_pkg::ST_WB_RD;
        end
      end
      default: state_d = bpsd_pkg::ST_LOAD;
    endcase
  end

  // datapath and output word
  always_comb begin
    cnt_d      = cnt_q;
    n_d        = n_q;
    err_d      = err_q;
    mask_d     = mask_q;
    idx_d      = idx_q;
    have_d     = have_q;
    best_d     = best_q;
    cur_d      = cur_q;
    cur_best_d = cur_best_q;
    level_d    = level_q;
    count_d    = count_q;
    o_item_d   = o_item_q;
    o_bin_d    = o_bin_q;
    o_cnt_d    = o_cnt_q;
    o_err_d    = o_err_q;
    o_last_d   = o_last_q;
    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = mask_q;
    ram_req_o.wdata = best_q;
    ram_req_o.raddr = pred;
    unique case (state_q)
      bpsd_pkg::ST_LOAD: begin
        if (accept) begin
          cnt_d = cnt_q + CW'(1);
          err_d = err_new;
          if (trigger) begin
            n_d      = cnt_q + CW'(1);
            mask_d   = {{(MW-1){1'b0}}, 1'b1};
            idx_d    = '0;
            have_d   = 1'b0;
            o_item_d = '0;
            o_bin_d  = '0;
            o_cnt_d  = '0;
            o_err_d  = 1'b1;
            o_last_d = 1'b1;
          end
        end
      end
      bpsd_pkg::ST_DP_RD: ram_req_o.raddr = pred;
      bpsd_pkg::ST_DP_EV: begin
        if (mask_q[idx_q] && (!have_q || less)) begin
          best_d = cand;
          have_d = 1'b1;
        end
        if (!idx_last) begin
          idx_d = idx_q + IW'(1);
        end
      end
      bpsd_pkg::ST_DP_WR: begin
        ram_req_o.we = 1'b1;
        mask_d = mask_q + MW'(1);
        idx_d  = '0;
        have_d = 1'b0;
      end
      bpsd_pkg::ST_WB_RD0: ram_req_o.raddr = full_mask;
      bpsd_pkg::ST_WB_LD0: begin
        cur_d      = full_mask;
        cur_best_d = ram_rdata_i;
        level_d    = '0;
        idx_d      = '0;
        count_d    = bpsd_pkg::BIN_CNT_W'(ram_rdata_i.closed) +
                     ((ram_rdata_i.load != '0) ? bpsd_pkg::BIN_CNT_W'(1) : '0);
      end
      bpsd_pkg::ST_WB_RD: ram_req_o.raddr = prev;
      bpsd_pkg::ST_WB_EV: begin
        if (cur_q[idx_q] && (m_fit || m_new)) begin
          o_item_d   = bpsd_pkg::ITEM_NUM_W'(idx_q) + bpsd_pkg::ITEM_NUM_W'(1);
          o_bin_d    = level_q;
          o_cnt_d    = count_q;
          o_err_d    = 1'b0;
          o_last_d   = (prev == '0);
          cur_d      = prev;
          cur_best_d = pb;
          if (!m_fit) begin
            level_d = level_q + bpsd_pkg::BIN_IDX_W'(1);
          end
        end else if (idx_last) begin
          cnt_d = '0;
          err_d = 1'b0;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      bpsd_pkg::ST_OUT: begin
        if (result_o.ready) begin
          idx_d = '0;
          if (o_last_q) begin
            cnt_d = '0;
            err_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // handshake and result word
  assign item_i.ready         = (state_q == bpsd_pkg::ST_LOAD);
  assign result_o.valid       = (state_q == bpsd_pkg::ST_OUT);
  assign result_o.item_number = o_item_q;
  assign result_o.bin_index   = o_bin_q;
  assign result_o.bin_count   = o_cnt_q;
  assign result_o.input_error = o_err_q;
  assign result_o.last_result = o_last_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpsd_pkg::ST_LOAD;
      cnt_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (wr_weight) begin
      weights_q[cnt_q[IW-1:0]] <= item_i.item_weight[WB-1:0];
    end
    n_q        <= n_d;
    mask_q     <= mask_d;
    idx_q      <= idx_d;
    have_q     <= have_d;
    best_q     <= best_d;
    cur_q      <= cur_d;
    cur_best_q <= cur_best_d;
    level_q    <= level_d;
    count_q    <= count_d;
    o_item_q   <= o_item_d;
    o_bin_q    <= o_bin_d;
    o_cnt_q    <= o_cnt_d;
    o_err_q    <= o_err_d;
    o_last_q   <= o_last_d;
  end

endmodule

`default_nettype wire
